FILE: sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, payload structs and lookup result type for the
// least-recently-used key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	// Built size of the store
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;
	localparam int ADDR_W  = 3;

	// Commands
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Register map (index of a 32-bit register)
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [AGE_W-1:0]         age_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef struct packed {
		logic  cmd;
		word_t key;
		word_t value;
	} in_item_t;

	typedef struct packed {
		logic  hit;
		word_t read_value;
	} out_item_t;

	// Lookup outcome for the request in the input register
	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		age_t hit_age;
		logic use_free;   // put miss fills an empty slot
		idx_t ins_idx;    // slot written by a put miss
	} look_t;

endpackage

FILE: sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement,
// get/put requests, one result beat per request.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  in        | in        | in_valid / in_stall        | in_data (cmd,key,value)
//  out       | out       | out_valid / out_stall      | out_data (hit,read_value)
//  config    | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One request beat is accepted every cycle unless the input side stalls;
//  its result beat passes the input register, then the result register.
//  The whole lookup and the age update are combinational from the input
//  register: the key compare over all entries sets the path.
//  Reset clears valid marks, ages, occupancy and capacity (16); keys and
//  values are held without reset and only read behind a valid mark.
//  A stalled result holds the result register, and a request beat waiting
//  behind it stalls the input side; no clearing pass is needed.
//
module lru_key_value_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lkv_pkg::in_item_t              in_data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output lkv_pkg::out_item_t             out_data,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkv_pkg::ADDR_W-1:0]     paddr,
	input  logic [lkv_pkg::DATA_W-1:0]     pwdata,
	output logic [lkv_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	// Configuration
	logic [lkv_pkg::CAP_W-1:0] cap_q;
	lkv_pkg::cnt_t             cap_eff;
	logic                      reg_sel;

	// Input stage
	logic                      valid_s1;
	lkv_pkg::in_item_t         item_s1;

	// Store
	logic [lkv_pkg::ENTRIES-1:0]           valid_q;
	lkv_pkg::age_t [lkv_pkg::ENTRIES-1:0]  age_q;
	lkv_pkg::word_t [lkv_pkg::ENTRIES-1:0] keys_q;
	lkv_pkg::word_t [lkv_pkg::ENTRIES-1:0] vals_q;
	lkv_pkg::cnt_t                         occ_q;

	// Next state
	logic [lkv_pkg::ENTRIES-1:0]           valid_d;
	lkv_pkg::age_t [lkv_pkg::ENTRIES-1:0]  age_d;
	lkv_pkg::cnt_t                         occ_d;

	lkv_pkg::look_t     look;
	lkv_pkg::out_item_t res;
	logic               advance;
	logic               s1_load;
	logic               fire;
	logic               is_put;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign reg_sel = (paddr[lkv_pkg::ADDR_W-1] == lkv_pkg::REG_CAPACITY);
	assign prdata  = reg_sel ? lkv_pkg::DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	// zero acts as one, anything past the built size as the built size
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lkv_pkg::cnt_t'(1);
		end else if (int'(cap_q) > lkv_pkg::ENTRIES) begin
			cap_eff = lkv_pkg::cnt_t'(lkv_pkg::ENTRIES);
		end else begin
			cap_eff = lkv_pkg::cnt_t'(cap_q);
		end
	end

	// ---- flow control ----
	// the input register moves on whenever the result register is free,
	// and an empty input register always takes a beat
	assign advance  = !out_valid || !out_stall;
	assign s1_load  = advance || !valid_s1;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// ---- lookup ----
	lkv_lookup u_lookup (
		.key   (item_s1.key),
		.valid (valid_q),
		.keys  (keys_q),
		.ages  (age_q),
		.occ   (occ_q),
		.cap   (cap_eff),
		.look  (look)
	);

	assign is_put = (item_s1.cmd == lkv_pkg::CMD_PUT);

	// ---- recency update ----
	// hit: entries younger than the hit entry age by one, hit goes to 0.
	// put miss into free slot: every valid entry ages, occupancy grows.
	// put miss with eviction: all but the victim age, victim reused at 0.
	always_comb begin
		valid_d = valid_q;
		age_d   = age_q;
		occ_d   = occ_q;
		if (look.hit) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (valid_q[i] && (age_q[i] < look.hit_age)) begin
					age_d[i] = age_q[i] + lkv_pkg::age_t'(1);
				end
			end
			age_d[look.hit_idx] = '0;
		end else if (is_put) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (valid_q[i]) begin
					age_d[i] = age_q[i] + lkv_pkg::age_t'(1);
				end
			end
			age_d[look.ins_idx]   = '0;
			valid_d[look.ins_idx] = 1'b1;
			if (look.use_free) begin
				occ_d = occ_q + lkv_pkg::cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '0;
			occ_q   <= '0;
		end else if (fire) begin
			valid_q <= valid_d;
			age_q   <= age_d;
			occ_q   <= occ_d;
		end
	end

	// keys and values: no reset, only read behind valid_q
	always_ff @(posedge clk) begin
		if (fire && is_put) begin
			if (look.hit) begin
				vals_q[look.hit_idx] <= item_s1.value;
			end else begin
				keys_q[look.ins_idx] <= item_s1.key;
				vals_q[look.ins_idx] <= item_s1.value;
			end
		end
	end

	// ---- result register ----
	always_comb begin
		res.hit        = look.hit;
		res.read_value = (look.hit && !is_put) ? vals_q[look.hit_idx]
		                                       : lkv_pkg::MISS_VALUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data <= res;
		end
	end

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= lkv_pkg::ENTRIES)
		else $error("occupancy above built size");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy does not match valid marks");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && look.hit |-> valid_q[look.hit_idx])
		else $error("hit on an invalid entry");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_put_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_put |=> valid_q[$past(look.hit ? look.hit_idx : look.ins_idx)])
		else $error("put left its slot invalid");
`endif

endmodule

FILE: sv/lkv_lookup.sv
// ----------------------------------------------------------------------------
// lkv_lookup
// Parallel key match, first-free search and victim selection for one
// request against the current contents of the store.
// ----------------------------------------------------------------------------
module lkv_lookup (
	input  lkv_pkg::word_t                      key,
	input  logic [lkv_pkg::ENTRIES-1:0]         valid,
	input  lkv_pkg::word_t [lkv_pkg::ENTRIES-1:0] keys,
	input  lkv_pkg::age_t  [lkv_pkg::ENTRIES-1:0] ages,
	input  lkv_pkg::cnt_t                       occ,
	input  lkv_pkg::cnt_t                       cap,
	output lkv_pkg::look_t                      look
);

	logic [lkv_pkg::ENTRIES-1:0] match;
	logic [lkv_pkg::ENTRIES-1:0] oldest;
	lkv_pkg::idx_t               free_idx;
	lkv_pkg::idx_t               old_idx;
	logic                        any_free;
	lkv_pkg::cnt_t               last_age;

	assign last_age = occ - lkv_pkg::cnt_t'(1);

	always_comb begin
		for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
			match[i]  = valid[i] && (keys[i] == key);
			// ages of valid entries are a permutation of 0..occ-1
			oldest[i] = valid[i] && (lkv_pkg::cnt_t'(ages[i]) == last_age);
		end
	end

	// Priority encoders, lowest index wins
	always_comb begin
		look.hit     = 1'b0;
		look.hit_idx = '0;
		free_idx     = '0;
		any_free     = 1'b0;
		old_idx      = '0;
		for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				look.hit     = 1'b1;
				look.hit_idx = lkv_pkg::idx_t'(i);
			end
			if (!valid[i]) begin
				any_free = 1'b1;
				free_idx = lkv_pkg::idx_t'(i);
			end
			if (oldest[i]) begin
				old_idx = lkv_pkg::idx_t'(i);
			end
		end
		look.hit_age  = ages[look.hit_idx];
		look.use_free = (occ < cap) && any_free;
		look.ins_idx  = look.use_free ? free_idx : old_idx;
	end

endmodule

FILE: sim/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache: a scoreboard class keeps
// its own copy of the store (keys, values, recency ages, occupancy and the
// capacity register) and predicts every result beat; directed beats, then
// randomised phases at several capacities with random idling and hold-offs.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

	localparam int UNUSED_REG_INDEX = 1;     // no register here, write is dropped
	localparam int PHASE_BEATS      = 160;   // request beats per random phase
	localparam int HOLD_CYCLES      = 80;    // long result hold-off
	localparam int SETTLE_CYCLES    = 8;     // quiet cycles once drained
	localparam int STALL_LIMIT      = 2000;  // cycles with no beat before giving up

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the store and queues the expected result beats
	// ------------------------------------------------------------------------
	class cache_scoreboard;
		lkv_pkg::word_t            slot_key [lkv_pkg::ENTRIES];
		lkv_pkg::word_t            slot_val [lkv_pkg::ENTRIES];
		bit                        slot_live[lkv_pkg::ENTRIES];
		int                        slot_age [lkv_pkg::ENTRIES];
		int                        live_count;
		logic [lkv_pkg::CAP_W-1:0] capacity;
		lkv_pkg::out_item_t        expected_q[$];
		int                        errors;

		function new();
			foreach (slot_live[i]) begin
				slot_key[i]  = '0;
				slot_val[i]  = '0;
				slot_live[i] = 1'b0;
				slot_age[i]  = 0;
			end
			live_count = 0;
			capacity   = lkv_pkg::CAP_RESET;
			errors     = 0;
		endfunction

		function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// Apply one accepted request to the mirror and queue its result
		function void note_request(lkv_pkg::in_item_t req);
			int                 found;
			int                 slot;
			int                 oldest;
			int                 cap;
			int                 pivot;
			lkv_pkg::out_item_t res;

			found = -1;
			foreach (slot_live[i])
				if (found < 0 && slot_live[i] && slot_key[i] === req.key)
					found = i;

			// register value 0 behaves as 1, anything above the built size as full
			cap = int'(capacity);
			if (cap < 1)
				cap = 1;
			if (cap > lkv_pkg::ENTRIES)
				cap = lkv_pkg::ENTRIES;

			res.hit        = (found >= 0);
			res.read_value = lkv_pkg::MISS_VALUE;

			if (found >= 0) begin
				if (req.cmd == lkv_pkg::CMD_GET)
					res.read_value = slot_val[found];
				else
					slot_val[found] = req.value;
				// promote: younger live entries age by one
				pivot = slot_age[found];
				foreach (slot_live[i])
					if (slot_live[i] && slot_age[i] < pivot)
						slot_age[i]++;
				slot_age[found] = 0;
			end else if (req.cmd == lkv_pkg::CMD_PUT) begin
				slot = -1;
				if (live_count < cap)
					foreach (slot_live[i])
						if (slot < 0 && !slot_live[i])
							slot = i;
				if (slot >= 0) begin
					foreach (slot_live[i])
						if (slot_live[i])
							slot_age[i]++;
					live_count++;
				end else begin
					// evict the oldest live entry; occupancy stays put
					oldest = 0;
					foreach (slot_live[i])
						if (slot_live[i] && (slot < 0 || slot_age[i] > oldest)) begin
							slot   = i;
							oldest = slot_age[i];
						end
					if (slot < 0) begin
						slot = 0;
						live_count++;
					end else begin
						foreach (slot_live[i])
							if (slot_live[i] && i != slot)
								slot_age[i]++;
					end
				end
				slot_live[slot] = 1'b1;
				slot_key[slot]  = req.key;
				slot_val[slot]  = req.value;
				slot_age[slot]  = 0;
			end
			expected_q.push_back(res);
		endfunction

		// Compare one accepted result beat with the oldest expectation
		function void check_result(lkv_pkg::out_item_t got);
			lkv_pkg::out_item_t want;

			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result beat hit=%0b read_value=%h",
						$time, got.hit, got.read_value);
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit || got.read_value !== want.read_value) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result mismatch: hit exp %0b got %0b, %s %h got %h",
						$time, want.hit, got.hit, "read_value exp",
						want.read_value, got.read_value);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT signals
	// ------------------------------------------------------------------------
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	lkv_pkg::in_item_t          in_data   = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	lkv_pkg::out_item_t         out_data;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [lkv_pkg::ADDR_W-1:0] paddr     = '0;
	logic [lkv_pkg::DATA_W-1:0] pwdata    = '0;
	logic [lkv_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	always #2 clk = ~clk;

	lru_key_value_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	cache_scoreboard sb = new();

	// Idling controls, set by the stimulus between phases
	bit tx_eager = 1'b1;    // sender offers back to back
	bit rx_eager = 1'b1;    // receiver never stalls on its own
	int hold_requests = 0;  // bumped by the stimulus to ask for a long hold-off

	// ------------------------------------------------------------------------
	// Result side: checks each accepted beat, then draws the stall before
	// the next one. A long hold-off is counted here, apart from the sender.
	// ------------------------------------------------------------------------
	int result_wait = 0;
	int hold_left   = 0;
	int hold_served = 0;

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(out_data);
			result_wait = rx_eager ? 0 : $urandom_range(0, 9);
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (result_wait > 0) begin
			out_stall <= 1'b1;
			result_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: counts cycles in which no beat moves on any port
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers. All are entered just after a rising edge and leave just after
	// the edge that completed their beat, so valid stays up into the next
	// beat with a single assignment per step.
	// ------------------------------------------------------------------------
	function automatic lkv_pkg::in_item_t make_request(logic cmd, lkv_pkg::word_t k,
			lkv_pkg::word_t v);
		lkv_pkg::in_item_t req;
		req.cmd   = cmd;
		req.key   = k;
		req.value = v;
		return req;
	endfunction

	task automatic send_request(input lkv_pkg::in_item_t req);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(req);
	endtask

	// Stop offering, let every result arrive, then a few quiet cycles
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write with a setup and an access phase; the register takes the data on the access edge
	task automatic write_register(input int index,
			input logic [lkv_pkg::DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lkv_pkg::ADDR_W'(4 * index);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == int'(lkv_pkg::REG_CAPACITY))
			sb.set_capacity(data[lkv_pkg::CAP_W-1:0]);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// Capacity per random phase: starts at 1 straight after a full store, so
	// the lowered-capacity case is hit first; 0, 31 and 17 probe the clamps.
	int             phase_caps[10] = '{1, 0, 2, 31, 17, 16, 3, 8, 5, 16};
	lkv_pkg::word_t key_pool[$];

	initial begin
		lkv_pkg::in_item_t req;
		int                pool_size;
		int                put_percent;
		int                cap;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed beats at the reset capacity ---
		send_request(make_request(lkv_pkg::CMD_GET, 32'sd0, 32'sd5));   // empty store
		send_request(make_request(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
		send_request(make_request(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
		send_request(make_request(lkv_pkg::CMD_PUT, 32'sd0, 32'sd0));
		send_request(make_request(lkv_pkg::CMD_PUT, -32'sd1, -32'sd1));
		send_request(make_request(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, -32'sd1)); // value ignored
		send_request(make_request(lkv_pkg::CMD_GET, 32'h8000_0000, 32'sd0));
		send_request(make_request(lkv_pkg::CMD_GET, 32'sd0, 32'sd0));
		send_request(make_request(lkv_pkg::CMD_GET, -32'sd1, 32'sd0));
		send_request(make_request(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h1234_5678));
		send_request(make_request(lkv_pkg::CMD_GET, 32'h8000_0000, 32'sd0));
		send_request(make_request(lkv_pkg::CMD_GET, 32'sd1, 32'sd0));   // miss
		// fill past the built size: the last put evicts the oldest entry
		for (int i = 0; i < 13; i++)
			send_request(make_request(lkv_pkg::CMD_PUT,
				lkv_pkg::word_t'(32'h100 + i), lkv_pkg::word_t'($urandom)));
		send_request(make_request(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'sd0)); // evicted
		send_request(make_request(lkv_pkg::CMD_GET, -32'sd1, 32'sd0));
		drain();

		// unknown register index: must leave the capacity alone
		write_register(UNUSED_REG_INDEX, 32'd1);

		// --- random phases ---
		for (int phase = 0; phase < 10; phase++) begin
			drain();
			cap = phase_caps[phase];
			if (phase == 9)
				cap = $urandom_range(1, lkv_pkg::ENTRIES);
			// upper data bits are don't-care for a 5-bit register
			write_register(int'(lkv_pkg::REG_CAPACITY),
				($urandom() & ~32'(2 ** lkv_pkg::CAP_W - 1)) | 32'(cap));
			if (phase == 6) begin
				@(posedge clk);
				write_register(UNUSED_REG_INDEX, 32'h0000_0001);
			end

			tx_eager    = (phase % 3 == 0) || (phase == 2) || (phase == 7);
			rx_eager    = (phase % 2 == 0);
			put_percent = $urandom_range(30, 70);

			// small key set so gets mostly hit; a few extremes mixed in
			pool_size = $urandom_range(4, 24);
			key_pool.delete();
			for (int i = 0; i < pool_size; i++)
				key_pool.push_back(lkv_pkg::word_t'($urandom));
			key_pool[0] = 32'h8000_0000;
			key_pool[1] = 32'h7FFF_FFFF;
			if (pool_size > 4) begin
				key_pool[2] = 32'sd0;
				key_pool[3] = -32'sd1;
			end

			for (int n = 0; n < PHASE_BEATS; n++) begin
				// receiver holds off while the sender keeps pushing
				if ((phase == 2 || phase == 7) && n == 40)
					hold_requests <= hold_requests + 1;
				req.cmd   = ($urandom_range(0, 99) < put_percent) ? lkv_pkg::CMD_PUT
					: lkv_pkg::CMD_GET;
				req.key   = ($urandom_range(0, 7) == 0) ? lkv_pkg::word_t'($urandom)
					: key_pool[$urandom_range(0, key_pool.size() - 1)];
				req.value = lkv_pkg::word_t'($urandom);
				send_request(req);
			end
		end

		drain();
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
